// ===== rtl/mhff_pkg.sv =====
// shared constants, types and character tables of the mail header field filter
`default_nettype none

package mhff_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // header tags that are recognized
  localparam int KW_NUM     = 7;
  localparam int KW_ERRORS  = 0;
  localparam int KW_PREC    = 1;
  localparam int KW_RETPATH = 2;
  localparam int KW_RESENT  = 3;
  localparam int KW_SENDER  = 4;
  localparam int KW_VIA     = 5;
  localparam int KW_XMAILER = 6;
  localparam int KW_MAXLEN  = 11;

  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
    "errors-to", "precedence", "return-path", "resent-", "sender", "via", "x-mailer"
  };
  localparam int KW_LEN [KW_NUM] = '{9, 10, 11, 7, 6, 3, 8};

  // inserted line when no precedence field was present
  localparam int PREC_LEN = 17;
  localparam int PREC_IDX_W = $clog2(PREC_LEN);
  localparam logic [8*PREC_LEN-1:0] PREC_TEXT = "Precedence: bulk\n";

  typedef struct packed {
    logic drop;
    logic is_prec;
  } tag_class_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_COLON);
  endfunction

  // byte c matches character pos of tag k (case-insensitive)
  function automatic logic kw_hit(input int k, input logic [7:0] pos, input logic [7:0] c);
    int l;
    int p;
    l = KW_LEN[k];
    p = int'(pos);
    if (p >= l) begin
      return 1'b0;
    end
    return to_lower(c) == KW_TEXT[k][8*(l-1-p) +: 8];
  endfunction

  function automatic logic [7:0] prec_byte(input logic [PREC_IDX_W-1:0] idx);
    return PREC_TEXT[8*(PREC_LEN-1-int'(idx)) +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mhff_if.sv =====
// valid/ready channel interfaces for message bytes in and filtered bytes out
`default_nettype none

interface mhff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface mhff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       message_done;
  logic       last_of_run;

  modport source (output valid, output out_byte, output message_done, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input message_done, input last_of_run,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/mail_header_field_filter.sv =====
// top level of the mail header field filter: line parser, tag buffer and output sequencer
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   msg_in   | in  | valid / ready | data_byte[7:0], end_of_message
//   msg_out  | out | valid / ready | out_byte[7:0], message_done, last_of_run
//
// an input beat that produces no output leaves msg_in.ready high; one that produces
// output beats holds msg_in.ready low until the output sequencer has loaded them all,
// with the SQ_TAG_RD state for the first tag ram read when buffered tag bytes are among
// them; the output sequencer sends one beat per cycle while msg_out is not stalled,
// from the tag ram, the inserted precedence line and the current byte, in that order
// rst is synchronous; after reset the block skips the first line of the message
// msg_out stalls hold the output register and freeze the sequencer
`default_nettype none

module mail_header_field_filter #(
  parameter int TAG_MAX = 40
) (
  input wire logic   clk,
  input wire logic   rst,
  mhff_in_if.sink    msg_in,
  mhff_out_if.source msg_out
);
  import mhff_pkg::*;

  localparam int LEN_W  = $clog2(TAG_MAX + 1);
  localparam int ADDR_W = $clog2(TAG_MAX);

  typedef enum logic [2:0] {
    PH_SKIP, PH_LINE, PH_TAG, PH_FIELD, PH_NL, PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_TAG_RD, SQ_TAG, SQ_PREC, SQ_FINAL
  } seq_t;

  // parser state
  phase_t           phase;
  logic [LEN_W-1:0] tag_length;
  logic             field_retained;
  logic             precedence_seen;

  // sequencer state
  seq_t                  sq_state;
  logic [ADDR_W-1:0]     rd_idx;
  logic [LEN_W-1:0]      sq_len;
  logic                  sq_prec;
  logic                  sq_fin;
  logic [7:0]            sq_fin_byte;
  logic                  sq_fin_done;
  logic [PREC_IDX_W-1:0] prec_idx;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_done;
  logic       out_last;

  // accept-time decisions
  logic             in_fire;
  logic [7:0]       b;
  logic             close;
  logic [LEN_W-1:0] close_len;
  logic             prec_req;
  logic             emit_prec;
  logic             fin;
  logic             fin_done;
  logic [7:0]       fin_byte;
  logic             fin_retained;
  phase_t           phase_next;
  logic [LEN_W-1:0] len_next;
  logic             retained_next;
  logic             prec_seen_next;
  logic [LEN_W-1:0] emit_len;
  logic             clear_all;
  tag_class_t       cls;

  // tag ram access
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              m_start;
  logic              m_step;

  logic             load_ok;
  logic             out_load;
  logic [LEN_W-1:0] idx_next;
  logic             tag_more;

  assign msg_in.ready = (sq_state == SQ_IDLE);
  assign in_fire      = msg_in.valid && msg_in.ready;
  assign b            = msg_in.data_byte;

  assign msg_out.valid        = out_valid;
  assign msg_out.out_byte     = out_byte;
  assign msg_out.message_done = out_done;
  assign msg_out.last_of_run  = out_last;

  assign load_ok  = !out_valid || msg_out.ready;
  // a sending state loads a new beat into the output register
  assign out_load = load_ok &&
                    (sq_state == SQ_TAG || sq_state == SQ_PREC || sq_state == SQ_FINAL);
  assign idx_next = LEN_W'(rd_idx) + LEN_W'(1);
  assign tag_more = idx_next < sq_len;

  mhff_ram #(
    .WIDTH (8),
    .DEPTH (TAG_MAX)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (b),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mhff_match #(
    .LEN_W (LEN_W)
  ) u_match (
    .clk     (clk),
    .start   (m_start),
    .step    (m_step),
    .data    (b),
    .pos     (tag_length),
    .cls_len (close_len),
    .cls     (cls)
  );

  // parse one accepted beat: what closes, what is written and what gets sent
  always_comb begin
    close      = 1'b0;
    close_len  = tag_length;
    prec_req   = 1'b0;
    fin        = 1'b0;
    fin_done   = 1'b0;
    fin_byte   = b;
    phase_next = phase;
    len_next   = tag_length;
    wr_en      = 1'b0;
    wr_addr    = tag_length[ADDR_W-1:0];
    m_start    = 1'b0;
    m_step     = 1'b0;
    clear_all  = 1'b0;

    if (in_fire) begin
      if (msg_in.end_of_message) begin
        // flush a pending tag, add the precedence line if still in the header
        close     = (phase == PH_TAG);
        prec_req  = (phase != PH_BODY);
        fin       = 1'b1;
        fin_done  = 1'b1;
        fin_byte  = 8'h00;
        clear_all = 1'b1;
      end else begin
        unique case (phase) inside
          PH_SKIP: begin
            if (b == CH_NL) begin
              phase_next = PH_LINE;
            end
          end
          PH_LINE, PH_NL: begin
            if (phase == PH_NL && (b == CH_SP || b == CH_TAB)) begin
              // continuation line of the current field
              fin        = field_retained;
              phase_next = PH_FIELD;
            end else if (b == CH_NL) begin
              // blank line: end of header
              prec_req   = 1'b1;
              fin        = 1'b1;
              phase_next = PH_BODY;
            end else begin
              // any other first byte of a line is a tag byte
              wr_en      = 1'b1;
              wr_addr    = '0;
              m_start    = 1'b1;
              len_next   = LEN_W'(1);
              phase_next = PH_TAG;
            end
          end
          PH_TAG: begin
            if (is_delim(b)) begin
              close      = 1'b1;
              fin        = !cls.drop;
              phase_next = (b == CH_NL) ? PH_NL : PH_FIELD;
            end else begin
              wr_en  = 1'b1;
              m_step = 1'b1;
              if (tag_length == LEN_W'(TAG_MAX - 1)) begin
                // tag buffer full: close now, next byte is field body
                close      = 1'b1;
                close_len  = LEN_W'(TAG_MAX);
                phase_next = PH_FIELD;
              end else begin
                len_next = tag_length + LEN_W'(1);
              end
            end
          end
          PH_FIELD: begin
            fin        = field_retained;
            phase_next = (b == CH_NL) ? PH_NL : PH_FIELD;
          end
          PH_BODY: begin
            fin = 1'b1;
          end
          default: begin
            phase_next = PH_SKIP;
          end
        endcase
      end
    end

    if (close) begin
      len_next = '0;
    end
    retained_next  = close ? !cls.drop : field_retained;
    prec_seen_next = precedence_seen || (close && cls.is_prec);
    emit_prec      = prec_req && !prec_seen_next;
    emit_len       = (close && !cls.drop) ? close_len : '0;
    fin_retained   = fin;
  end

  // tag ram read port follows the sequencer
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (sq_state == SQ_TAG_RD) begin
      rd_en = 1'b1;
    end else if (sq_state == SQ_TAG && load_ok && tag_more) begin
      rd_en   = 1'b1;
      rd_addr = idx_next[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SKIP;
      tag_length      <= '0;
      field_retained  <= 1'b1;
      precedence_seen <= 1'b0;
      sq_state        <= SQ_IDLE;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && msg_out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (sq_state)
        SQ_IDLE: begin
          if (in_fire) begin
            if (clear_all) begin
              phase           <= PH_SKIP;
              tag_length      <= '0;
              field_retained  <= 1'b1;
              precedence_seen <= 1'b0;
            end else begin
              phase           <= phase_next;
              tag_length      <= len_next;
              field_retained  <= retained_next;
              precedence_seen <= prec_seen_next;
            end
            sq_len      <= emit_len;
            sq_prec     <= emit_prec;
            sq_fin      <= fin_retained;
            sq_fin_byte <= fin_byte;
            sq_fin_done <= fin_done;
            prec_idx    <= '0;
            if (emit_len != '0) begin
              sq_state <= SQ_TAG_RD;
            end else if (emit_prec) begin
              sq_state <= SQ_PREC;
            end else if (fin_retained) begin
              sq_state <= SQ_FINAL;
            end
          end
        end
        SQ_TAG_RD: begin
          rd_idx   <= '0;
          sq_state <= SQ_TAG;
        end
        SQ_TAG: begin
          if (load_ok) begin
            out_byte  <= rd_data;
            out_done  <= 1'b0;
            out_last  <= !tag_more && !sq_prec && !sq_fin;
            if (tag_more) begin
              rd_idx <= idx_next[ADDR_W-1:0];
            end else if (sq_prec) begin
              sq_state <= SQ_PREC;
            end else if (sq_fin) begin
              sq_state <= SQ_FINAL;
            end else begin
              sq_state <= SQ_IDLE;
            end
          end
        end
        SQ_PREC: begin
          if (load_ok) begin
            out_byte  <= prec_byte(prec_idx);
            out_done  <= 1'b0;
            out_last  <= (prec_idx == PREC_IDX_W'(PREC_LEN - 1)) && !sq_fin;
            if (prec_idx == PREC_IDX_W'(PREC_LEN - 1)) begin
              sq_state <= sq_fin ? SQ_FINAL : SQ_IDLE;
            end else begin
              prec_idx <= prec_idx + PREC_IDX_W'(1);
            end
          end
        end
        SQ_FINAL: begin
          if (load_ok) begin
            out_byte  <= sq_fin_byte;
            out_done  <= sq_fin_done;
            out_last  <= 1'b1;
            sq_state  <= SQ_IDLE;
          end
        end
        default: begin
          sq_state <= SQ_IDLE;
        end
      endcase
    end
  end

  // end of message always closes a run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("message_done beat without last_of_run");

  // tag buffer never holds a full tag between beats
  assert property (@(posedge clk) disable iff (rst)
    tag_length < LEN_W'(TAG_MAX))
    else $error("tag length reached buffer size");

  // end of message returns the parser to its reset state
  assert property (@(posedge clk) disable iff (rst)
    in_fire && msg_in.end_of_message |=>
      phase == PH_SKIP && tag_length == '0 && !precedence_seen && field_retained)
    else $error("parser not cleared after end of message");

  // tag readout stays inside the buffered tag
  assert property (@(posedge clk) disable iff (rst)
    sq_state == SQ_TAG |-> LEN_W'(rd_idx) < sq_len)
    else $error("tag readout past tag length");

endmodule

`default_nettype wire

// ===== rtl/mhff_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module mhff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhff_match.sv =====
// running case-insensitive match of the buffered tag against the known tags
`default_nettype none

module mhff_match #(
  parameter int LEN_W = 6
) (
  input  wire logic               clk,
  input  wire logic               start,
  input  wire logic               step,
  input  wire logic [7:0]         data,
  input  wire logic [LEN_W-1:0]   pos,
  input  wire logic [LEN_W-1:0]   cls_len,
  output mhff_pkg::tag_class_t    cls
);
  import mhff_pkg::*;

  logic [KW_NUM-1:0] flags;
  logic [KW_NUM-1:0] flags_next;
  logic [KW_NUM-1:0] exact;

  for (genvar k = 0; k < KW_NUM; k++) begin : g_kw
    always_comb begin
      flags_next[k] = flags[k];
      if (start) begin
        flags_next[k] = kw_hit(k, 8'd0, data);
      end else if (step) begin
        if (k == KW_RESENT) begin
          // prefix match: bytes past the prefix do not matter
          flags_next[k] = flags[k] &&
                          ((8'(pos) >= 8'(KW_LEN[k])) || kw_hit(k, 8'(pos), data));
        end else begin
          flags_next[k] = flags[k] && kw_hit(k, 8'(pos), data);
        end
      end
    end
    assign exact[k] = flags[k] && (cls_len == LEN_W'(KW_LEN[k]));
  end

  always_ff @(posedge clk) begin
    flags <= flags_next;
  end

  always_comb begin
    cls.drop = exact[KW_ERRORS] || exact[KW_RETPATH] || exact[KW_SENDER] ||
               exact[KW_VIA] || exact[KW_XMAILER] ||
               (flags[KW_RESENT] && (cls_len >= LEN_W'(KW_LEN[KW_RESENT])));
    cls.is_prec = exact[KW_PREC];
  end

endmodule

`default_nettype wire
